### design/ccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and helpers for the clock calendar set controller
// Command, edit mode and clock register codes, the queue entry that passes
// from the front part to the back part, and the BCD and calendar helpers.
// ----------------------------------------------------------------------------
package ccs_pkg;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_MODE = 2'd0;
    localparam cmd_t CMD_UP   = 2'd1;
    localparam cmd_t CMD_DOWN = 2'd2;
    localparam cmd_t CMD_LOAD = 2'd3;

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_RUN    = 3'd0;
    localparam mode_t MODE_DAY    = 3'd1;
    localparam mode_t MODE_MONTH  = 3'd2;
    localparam mode_t MODE_YEAR   = 3'd3;
    localparam mode_t MODE_HOUR   = 3'd4;
    localparam mode_t MODE_MINUTE = 3'd5;
    localparam mode_t MODE_SECOND = 3'd6;

    typedef logic [2:0] clk_reg_t;
    localparam clk_reg_t REG_SEC   = 3'd0;
    localparam clk_reg_t REG_MIN   = 3'd1;
    localparam clk_reg_t REG_HOUR  = 3'd2;
    localparam clk_reg_t REG_DAY   = 3'd4;
    localparam clk_reg_t REG_MONTH = 3'd5;
    localparam clk_reg_t REG_YEAR  = 3'd6;

    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [4:0] DAY_MAX   = 5'd31;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [6:0] YEAR_MAX  = 7'd99;

    // One event's results: a first result, and optionally a day write after it
    typedef struct packed {
        mode_t      mode;
        logic       first_valid;
        clk_reg_t   first_reg;
        logic [7:0] first_data;
        logic       two;
        logic [7:0] second_data;
    } ccs_entry_t;

    typedef struct packed {
        logic       valid;
        ccs_entry_t entry;
    } ccs_head_t;

    // Binary 0..99 to two BCD digits; tens by reciprocal multiply
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  units;
        prod     = {7'd0, v} * 14'd103;
        tens     = prod[13:10];
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        units    = v - tens_x10;
        return {tens, units[3:0]};
    endfunction

    // Two nibbles read as tens and units, saturated at max
    function automatic logic [7:0] from_bcd(input logic [7:0] b, input logic [7:0] max);
        logic [7:0] v;
        v = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'd0, b[3:0]};
        return (v > max) ? max : v;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

### design/ccs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_front: event decode and field update
// Holds the edit mode and the six time and date fields, applies one event
// per transfer and builds the queue entry with its register writes.
// ----------------------------------------------------------------------------
module ccs_front
    import ccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_t       command,
    input  logic [7:0] sec_bcd,
    input  logic [7:0] min_bcd,
    input  logic [7:0] hour_bcd,
    input  logic [7:0] day_bcd,
    input  logic [7:0] month_bcd,
    input  logic [7:0] year_bcd,
    output ccs_entry_t entry
);

    mode_t      mode_reg,    mode_next;
    logic [5:0] seconds_reg, seconds_next;
    logic [5:0] minutes_reg, minutes_next;
    logic [4:0] hours_reg,   hours_next;
    logic [4:0] day_reg,     day_next;
    logic [3:0] month_reg,   month_next;
    logic [6:0] year_reg,    year_next;

    logic       is_up;
    logic [4:0] cur_len;
    logic [3:0] month_inc;
    logic [4:0] inc_len;
    logic [7:0] ld_sec, ld_min, ld_hour, ld_day, ld_month, ld_year;

    assign is_up     = (command == CMD_UP);
    assign cur_len   = month_len(month_reg);
    assign month_inc = month_reg + 4'd1;
    assign inc_len   = month_len(month_inc);

    assign ld_sec   = from_bcd(sec_bcd,   {2'b00, SEC_MAX});
    assign ld_min   = from_bcd(min_bcd,   {2'b00, MIN_MAX});
    assign ld_hour  = from_bcd(hour_bcd,  {3'b000, HOUR_MAX});
    assign ld_day   = from_bcd(day_bcd,   {3'b000, DAY_MAX});
    assign ld_month = from_bcd(month_bcd, {4'd0, MONTH_MAX});
    assign ld_year  = from_bcd(year_bcd,  {1'b0, YEAR_MAX});

    always_comb
    begin
        mode_next    = mode_reg;
        seconds_next = seconds_reg;
        minutes_next = minutes_reg;
        hours_next   = hours_reg;
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        entry        = '0;

        case (command)
            CMD_MODE:
            begin
                mode_next = (mode_reg >= MODE_SECOND) ? MODE_RUN : mode_reg + 3'd1;
            end
            CMD_LOAD:
            begin
                if (mode_reg == MODE_RUN)
                begin
                    seconds_next = ld_sec[5:0];
                    minutes_next = ld_min[5:0];
                    hours_next   = ld_hour[4:0];
                    day_next     = ld_day[4:0];
                    month_next   = ld_month[3:0];
                    year_next    = ld_year[6:0];
                end
            end
            default:
            begin
                case (mode_reg)
                    MODE_DAY:
                    begin
                        if (is_up)
                        begin
                            // no write while the month is not a real one
                            if (month_reg >= 4'd1 && month_reg <= MONTH_MAX)
                            begin
                                day_next          = (day_reg >= cur_len) ? cur_len
                                                                         : day_reg + 5'd1;
                                entry.first_valid = 1'b1;
                                entry.first_reg   = REG_DAY;
                                entry.first_data  = to_bcd({2'b00, day_next});
                            end
                        end
                        else
                        begin
                            day_next          = (day_reg <= 5'd1) ? 5'd1 : day_reg - 5'd1;
                            entry.first_valid = 1'b1;
                            entry.first_reg   = REG_DAY;
                            entry.first_data  = to_bcd({2'b00, day_next});
                        end
                    end
                    MODE_MONTH:
                    begin
                        entry.first_valid = 1'b1;
                        entry.first_reg   = REG_MONTH;
                        if (is_up)
                        begin
                            if (month_reg >= MONTH_MAX)
                            begin
                                month_next = MONTH_MAX;
                            end
                            else
                            begin
                                // clamp the day to the new month and write it too
                                month_next = month_inc;
                                if (day_reg > inc_len && inc_len < DAY_MAX)
                                begin
                                    day_next = inc_len;
                                end
                                entry.two         = 1'b1;
                                entry.second_data = to_bcd({2'b00, day_next});
                            end
                        end
                        else
                        begin
                            month_next = (month_reg <= 4'd1) ? 4'd1 : month_reg - 4'd1;
                        end
                        entry.first_data = to_bcd({3'b000, month_next});
                    end
                    MODE_YEAR:
                    begin
                        if (is_up)
                            year_next = (year_reg >= YEAR_MAX) ? YEAR_MAX : year_reg + 7'd1;
                        else
                            year_next = (year_reg == 7'd0) ? 7'd0 : year_reg - 7'd1;
                        entry.first_valid = 1'b1;
                        entry.first_reg   = REG_YEAR;
                        entry.first_data  = to_bcd(year_next);
                    end
                    MODE_HOUR:
                    begin
                        if (is_up)
                            hours_next = (hours_reg >= HOUR_MAX) ? HOUR_MAX : hours_reg + 5'd1;
                        else
                            hours_next = (hours_reg == 5'd0) ? 5'd0 : hours_reg - 5'd1;
                        entry.first_valid = 1'b1;
                        entry.first_reg   = REG_HOUR;
                        entry.first_data  = to_bcd({2'b00, hours_next});
                    end
                    MODE_MINUTE:
                    begin
                        if (is_up)
                            minutes_next = (minutes_reg >= MIN_MAX) ? MIN_MAX
                                                                    : minutes_reg + 6'd1;
                        else
                            minutes_next = (minutes_reg == 6'd0) ? 6'd0 : minutes_reg - 6'd1;
                        entry.first_valid = 1'b1;
                        entry.first_reg   = REG_MIN;
                        entry.first_data  = to_bcd({1'b0, minutes_next});
                    end
                    MODE_SECOND:
                    begin
                        if (is_up)
                            seconds_next = (seconds_reg >= SEC_MAX) ? SEC_MAX
                                                                    : seconds_reg + 6'd1;
                        else
                            seconds_next = (seconds_reg == 6'd0) ? 6'd0 : seconds_reg - 6'd1;
                        entry.first_valid = 1'b1;
                        entry.first_reg   = REG_SEC;
                        entry.first_data  = to_bcd({1'b0, seconds_next});
                    end
                    default:
                    begin
                        entry.first_valid = 1'b0;
                    end
                endcase
            end
        endcase

        entry.mode = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RUN;
            seconds_reg <= '0;
            minutes_reg <= '0;
            hours_reg   <= '0;
            day_reg     <= '0;
            month_reg   <= '0;
            year_reg    <= '0;
        end
        else if (push)
        begin
            mode_reg    <= mode_next;
            seconds_reg <= seconds_next;
            minutes_reg <= minutes_next;
            hours_reg   <= hours_next;
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
        end
    end

endmodule

### design/ccs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_queue: two-entry queue between decode and write sequencing
// Holds decoded events so that the front can keep taking transfers while the
// back waits on the output side.
// ----------------------------------------------------------------------------
module ccs_queue
    import ccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ccs_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output ccs_head_t  head
);

    ccs_entry_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/ccs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_back: register write sequencer
// Presents the queue head as one or two result transfers and releases the
// entry once its last result has been taken.
// ----------------------------------------------------------------------------
module ccs_back
    import ccs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ccs_head_t   head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'b01,
        PH_SECOND = 2'b10
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       wr_valid;
    clk_reg_t   wr_reg;
    logic [7:0] wr_data;
    logic       xfer;

    always_comb
    begin
        case (phase_reg)
            PH_SECOND:
            begin
                wr_valid = 1'b1;
                wr_reg   = REG_DAY;
                wr_data  = head.entry.second_data;
                m_tlast  = 1'b1;
            end
            default:
            begin
                wr_valid = head.entry.first_valid;
                wr_reg   = head.entry.first_reg;
                wr_data  = head.entry.first_data;
                m_tlast  = ~head.entry.two;
            end
        endcase
    end

    assign m_tvalid = head.valid;
    assign m_tdata  = {2'b00, wr_data, wr_reg, head.entry.mode};
    assign m_tuser  = wr_valid;
    assign xfer     = m_tvalid & m_tready;
    assign pop      = xfer & m_tlast;

    always_comb
    begin
        phase_next = phase_reg;
        if (xfer)
        begin
            phase_next = m_tlast ? PH_FIRST : PH_SECOND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_FIRST;
        else
            phase_reg <= phase_next;
    end

endmodule

### design/clock_calendar_set_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_calendar_set_controller: set-mode control for a clock and calendar
//
//   channel   dir  tvalid/tready       payload
//   s_*       in   s_tvalid/s_tready   tuser command, tdata six BCD fields
//   m_*       out  m_tvalid/m_tready   tuser write_valid, tdata mode/reg/data,
//                                      tlast end of event
//
// An event is taken on an s_* transfer and leaves as one or two result
// transfers, each held until m_tready; a month raise gives two, so it sets the
// pace through the single output port. A two-entry queue sits between the
// decode and the write sequencer, so s_tready drops only when both entries
// wait on m_tready. Reset returns to run mode with all fields at zero.
// ----------------------------------------------------------------------------
module clock_calendar_set_controller
    import ccs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sec_bcd, min_bcd, hour_bcd, day_bcd, month_bcd, year_bcd
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // edit_mode, write_register, write_data, zero pad
    output logic [0:0]  m_tuser,   // write_valid
    output logic        m_tlast    // last
);

    logic       push;
    logic       pop;
    logic       full;
    ccs_entry_t entry;
    ccs_head_t  head;

    assign s_tready = ~full;
    assign push     = s_tvalid & s_tready;

    ccs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .command   (s_tuser),
        .sec_bcd   (s_tdata[7:0]),
        .min_bcd   (s_tdata[15:8]),
        .hour_bcd  (s_tdata[23:16]),
        .day_bcd   (s_tdata[31:24]),
        .month_bcd (s_tdata[39:32]),
        .year_bcd  (s_tdata[47:40]),
        .entry     (entry)
    );

    ccs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .full       (full),
        .head       (head)
    );

    ccs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### dv/tb_clock_calendar_set_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_calendar_set_controller: self-checking bench for the set controller
// Sends button and load events into the block and mirrors its edit mode and
// time/date fields in a local model. The model predicts the register writes,
// and each output transfer is checked field by field against them. A short
// table of events comes first, then a long random run. The run passes
// through phases with no idling, a slow sender, a stalling sink, and both.
// ----------------------------------------------------------------------------
module tb_clock_calendar_set_controller;
    import ccs_pkg::*;

    localparam int RANDOM_EVENTS = 1750;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_PRINTS    = 40;

    typedef struct {
        mode_t      mode;
        logic       wr;
        clk_reg_t   wreg;
        logic [7:0] data;
        logic       last;
    } clk_write_t;

    typedef struct {
        cmd_t        cmd;
        logic [47:0] fields;
        bit          typed;
        clk_write_t  want;
    } dir_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // sec_bcd, min_bcd, hour_bcd, day_bcd, month_bcd, year_bcd
    logic [1:0]  s_tuser  = '0;   // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // edit_mode, write_register, write_data, zero pad
    logic [0:0]  m_tuser;         // write_valid
    logic        m_tlast;         // last

    // Mirror of the block's state
    mode_t      cur_mode;
    logic [5:0] sec_q;
    logic [5:0] min_q;
    logic [4:0] hour_q;
    logic [4:0] day_q;
    logic [3:0] month_q;
    logic [6:0] year_q;

    clk_write_t expected_writes[$];
    int         mismatches     = 0;
    int         idle_cycles    = 0;
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;

    clock_calendar_set_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [4:0] days_of(input logic [3:0] m);
        case (m)
            4'd2:                    return 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:      return 5'd31;
            default:                 return 5'd0;
        endcase
    endfunction

    function automatic logic [7:0] bin_to_bcd(input int v);
        logic [3:0] tens;
        logic [3:0] units;
        tens  = 4'(v / 10);
        units = 4'(v % 10);
        return {tens, units};
    endfunction

    // Nibbles taken as tens and units even above nine, then clipped
    function automatic int bcd_clip(input logic [7:0] b, input int top);
        int v;
        v = int'(b[7:4]) * 10 + int'(b[3:0]);
        return (v > top) ? top : v;
    endfunction

    function automatic dir_row_t mk_row(input cmd_t c, input logic [47:0] f, input bit typed,
                                        input mode_t m, input logic wv, input clk_reg_t r,
                                        input logic [7:0] d);
        dir_row_t row;
        row.cmd       = c;
        row.fields    = f;
        row.typed     = typed;
        row.want.mode = m;
        row.want.wr   = wv;
        row.want.wreg = r;
        row.want.data = d;
        row.want.last = 1'b1;
        return row;
    endfunction

    task automatic post_write(input logic wr, input clk_reg_t r, input int v, input logic last);
        clk_write_t w;
        w.mode = cur_mode;
        w.wr   = wr;
        w.wreg = wr ? r : REG_SEC;
        w.data = wr ? bin_to_bcd(v) : 8'h00;
        w.last = last;
        expected_writes.push_back(w);
    endtask

    task automatic predict_event(input cmd_t cmd, input logic [47:0] f);
        logic       up;
        logic [4:0] mlen;
        up = (cmd == CMD_UP);
        if (cmd == CMD_MODE)
        begin
            cur_mode = (cur_mode >= MODE_SECOND) ? MODE_RUN : cur_mode + 3'd1;
            post_write(1'b0, REG_SEC, 0, 1'b1);
        end
        else if (cmd == CMD_LOAD)
        begin
            // outside run mode a load is dropped
            if (cur_mode == MODE_RUN)
            begin
                sec_q   = 6'(bcd_clip(f[7:0],   SEC_MAX));
                min_q   = 6'(bcd_clip(f[15:8],  MIN_MAX));
                hour_q  = 5'(bcd_clip(f[23:16], HOUR_MAX));
                day_q   = 5'(bcd_clip(f[31:24], DAY_MAX));
                month_q = 4'(bcd_clip(f[39:32], MONTH_MAX));
                year_q  = 7'(bcd_clip(f[47:40], YEAR_MAX));
            end
            post_write(1'b0, REG_SEC, 0, 1'b1);
        end
        else
        begin
            case (cur_mode)
                MODE_DAY:
                begin
                    if (up)
                    begin
                        if (month_q >= 4'd1 && month_q <= 4'd12)
                        begin
                            mlen  = days_of(month_q);
                            day_q = (day_q >= mlen) ? mlen : day_q + 5'd1;
                            post_write(1'b1, REG_DAY, day_q, 1'b1);
                        end
                        else
                            post_write(1'b0, REG_SEC, 0, 1'b1);
                    end
                    else
                    begin
                        day_q = (day_q <= 5'd1) ? 5'd1 : day_q - 5'd1;
                        post_write(1'b1, REG_DAY, day_q, 1'b1);
                    end
                end
                MODE_MONTH:
                begin
                    if (up && month_q >= MONTH_MAX)
                    begin
                        month_q = MONTH_MAX;
                        post_write(1'b1, REG_MONTH, month_q, 1'b1);
                    end
                    else if (up)
                    begin
                        // a raise also rewrites the day, clamped to the new month
                        month_q = month_q + 4'd1;
                        post_write(1'b1, REG_MONTH, month_q, 1'b0);
                        mlen = days_of(month_q);
                        if (day_q > mlen && mlen < 5'd31)
                            day_q = mlen;
                        post_write(1'b1, REG_DAY, day_q, 1'b1);
                    end
                    else
                    begin
                        month_q = (month_q <= 4'd1) ? 4'd1 : month_q - 4'd1;
                        post_write(1'b1, REG_MONTH, month_q, 1'b1);
                    end
                end
                MODE_YEAR:
                begin
                    if (up)
                        year_q = (year_q >= YEAR_MAX) ? YEAR_MAX : year_q + 7'd1;
                    else
                        year_q = (year_q == 7'd0) ? 7'd0 : year_q - 7'd1;
                    post_write(1'b1, REG_YEAR, year_q, 1'b1);
                end
                MODE_HOUR:
                begin
                    if (up)
                        hour_q = (hour_q >= HOUR_MAX) ? HOUR_MAX : hour_q + 5'd1;
                    else
                        hour_q = (hour_q == 5'd0) ? 5'd0 : hour_q - 5'd1;
                    post_write(1'b1, REG_HOUR, hour_q, 1'b1);
                end
                MODE_MINUTE:
                begin
                    if (up)
                        min_q = (min_q >= MIN_MAX) ? MIN_MAX : min_q + 6'd1;
                    else
                        min_q = (min_q == 6'd0) ? 6'd0 : min_q - 6'd1;
                    post_write(1'b1, REG_MIN, min_q, 1'b1);
                end
                MODE_SECOND:
                begin
                    if (up)
                        sec_q = (sec_q >= SEC_MAX) ? SEC_MAX : sec_q + 6'd1;
                    else
                        sec_q = (sec_q == 6'd0) ? 6'd0 : sec_q - 6'd1;
                    post_write(1'b1, REG_SEC, sec_q, 1'b1);
                end
                default:
                    post_write(1'b0, REG_SEC, 0, 1'b1);
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTS)
            $display("%0t: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_write();
        clk_write_t want;
        if (expected_writes.size() == 0)
        begin
            report_mismatch("unexpected transfer", m_tdata, 0);
            return;
        end
        want = expected_writes.pop_front();
        if (m_tdata[2:0] !== want.mode)
            report_mismatch("edit_mode", m_tdata[2:0], want.mode);
        if (m_tuser[0] !== want.wr)
            report_mismatch("write_valid", m_tuser[0], want.wr);
        if (m_tdata[5:3] !== want.wreg)
            report_mismatch("write_register", m_tdata[5:3], want.wreg);
        if (m_tdata[13:6] !== want.data)
            report_mismatch("write_data", m_tdata[13:6], want.data);
        if (m_tlast !== want.last)
            report_mismatch("last", m_tlast, want.last);
    endtask

    // Hold the event until the transfer, then update the model
    task automatic send_event(input cmd_t cmd, input logic [47:0] f);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= f;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        predict_event(cmd, f);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            check_write();
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        dir_row_t    rows[$];
        cmd_t        cmd;
        logic [47:0] f;
        int          counted;
        int          phase;
        int          pick;

        cur_mode = MODE_RUN;
        sec_q    = '0;
        min_q    = '0;
        hour_q   = '0;
        day_q    = '0;
        month_q  = '0;
        year_q   = '0;

        // up and down in run mode, then a load with digits above nine
        rows.push_back(mk_row(CMD_UP,   '0, 1, MODE_RUN, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_DOWN, '0, 1, MODE_RUN, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_LOAD, 48'hF0_01_31_24_99_FF, 1, MODE_RUN, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_MODE, '0, 1, MODE_DAY, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_UP,   '0, 1, MODE_DAY, 1'b1, REG_DAY, 8'h31));
        rows.push_back(mk_row(CMD_LOAD, '0, 1, MODE_DAY, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_MODE, '0, 1, MODE_MONTH, 1'b0, REG_SEC, 8'h00));
        // January to February clamps the day to 28
        rows.push_back(mk_row(CMD_UP,   '0, 0, MODE_RUN, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_DOWN, '0, 1, MODE_MONTH, 1'b1, REG_MONTH, 8'h01));
        rows.push_back(mk_row(CMD_MODE, '0, 1, MODE_YEAR, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_UP,   '0, 1, MODE_YEAR, 1'b1, REG_YEAR, 8'h99));
        rows.push_back(mk_row(CMD_MODE, '0, 1, MODE_HOUR, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_UP,   '0, 1, MODE_HOUR, 1'b1, REG_HOUR, 8'h23));
        rows.push_back(mk_row(CMD_MODE, '0, 1, MODE_MINUTE, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_UP,   '0, 1, MODE_MINUTE, 1'b1, REG_MIN, 8'h59));
        rows.push_back(mk_row(CMD_MODE, '0, 1, MODE_SECOND, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_UP,   '0, 1, MODE_SECOND, 1'b1, REG_SEC, 8'h59));
        rows.push_back(mk_row(CMD_DOWN, '0, 0, MODE_RUN, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_MODE, '0, 1, MODE_RUN, 1'b0, REG_SEC, 8'h00));
        // all-zero load leaves the month invalid
        rows.push_back(mk_row(CMD_LOAD, '0, 1, MODE_RUN, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_MODE, '0, 1, MODE_DAY, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_UP,   '0, 1, MODE_DAY, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_DOWN, '0, 1, MODE_DAY, 1'b1, REG_DAY, 8'h01));
        rows.push_back(mk_row(CMD_MODE, '0, 1, MODE_MONTH, 1'b0, REG_SEC, 8'h00));
        rows.push_back(mk_row(CMD_DOWN, '0, 1, MODE_MONTH, 1'b1, REG_MONTH, 8'h01));
        rows.push_back(mk_row(CMD_UP,   '0, 0, MODE_RUN, 1'b0, REG_SEC, 8'h00));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_event(rows[i].cmd, rows[i].fields);
            if (rows[i].typed)
            begin
                void'(expected_writes.pop_back());
                expected_writes.push_back(rows[i].want);
            end
        end

        counted = 0;
        while (counted < RANDOM_EVENTS)
        begin
            phase = counted * 4 / RANDOM_EVENTS;
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 85;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 85;
                end
                default:
                begin
                    src_idle_pct   = 33;
                    sink_stall_pct = 33;
                end
            endcase

            pick = $urandom_range(99);
            if (pick < 20)
                cmd = CMD_MODE;
            else if (pick < 55)
                cmd = CMD_UP;
            else if (pick < 88)
                cmd = CMD_DOWN;
            else
                cmd = CMD_LOAD;

            f = {16'($urandom), $urandom};
            // most loads carry a plausible time and date
            if (cmd == CMD_LOAD && $urandom_range(99) < 75)
                f = {bin_to_bcd($urandom_range(99)), bin_to_bcd($urandom_range(12, 1)),
                     bin_to_bcd($urandom_range(31, 1)), bin_to_bcd($urandom_range(23)),
                     bin_to_bcd($urandom_range(59)), bin_to_bcd($urandom_range(59))};

            if (!(cmd == CMD_LOAD && cur_mode != MODE_RUN))
                counted++;
            send_event(cmd, f);
        end
        s_tvalid       <= 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;

        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### clock_calendar_set_controller.f
design/ccs_pkg.sv
design/ccs_front.sv
design/ccs_queue.sv
design/ccs_back.sv
design/clock_calendar_set_controller.sv
dv/tb_clock_calendar_set_controller.sv
